### sv/crcp_pkg.sv
// Shared constants, command/status types and lookup functions for the cube projector.
package crcp_pkg;

  localparam int COORD_W = 16;
  localparam int FOCUS_W = 18;
  localparam int TRIG_W  = 15;
  localparam int SCALE_W = 12;
  localparam int CTR_W   = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int OPA_W  = 36;
  localparam int OPB_W  = 20;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = 58;
  localparam int NUM_W  = 48;
  localparam int DEN_W  = 19;
  localparam int T_W    = 28;
  localparam int DIFF_W = COORD_W + 1;
  localparam int EX_W   = 20;
  localparam int NUM_FACES = 6;

  localparam logic [16:0] STRETCH_Q16 = 17'd35389;
  localparam logic signed [COORD_W-1:0] ONE_COORD = 16'sd8192;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FOCUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CTR_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CTR_Y = 3'd5;

  localparam logic [FOCUS_W-1:0] FOCUS_RST = 18'd24576;
  localparam logic [TRIG_W-1:0]  COS_RST   = 15'd16302;
  localparam logic [TRIG_W-1:0]  SIN_RST   = 15'd1636;
  localparam logic [SCALE_W-1:0] SCALE_RST = 12'd276;
  localparam logic [CTR_W-1:0]   CTR_RST   = 12'd256;

  // command modes
  localparam logic [1:0] MODE_ROT_X = 2'd0;
  localparam logic [1:0] MODE_ROT_Y = 2'd1;
  localparam logic [1:0] MODE_ROT_Z = 2'd2;
  localparam logic [1:0] MODE_HOLD  = 2'd3;

  typedef enum logic [3:0] {
    A_RP, A_RQ, A_AX, A_AY, A_AZ, A_CX, A_CY, A_CZ, A_T, A_D
  } a_sel_t;

  typedef enum logic [3:0] {
    B_C, B_S, B_BX, B_BY, B_BZ, B_EX, B_Y0, B_Z0, B_VS, B_K, B_CTRX, B_CTRY
  } b_sel_t;

  typedef enum logic [2:0] {
    ACC_NONE, ACC_LD, ACC_ADD, ACC_SUB, ACC_ADD16
  } acc_op_t;

  typedef enum logic [3:0] {
    M_NONE, M_TAKE_IN, M_LATCH_ROT, M_WRITE_P, M_WRITE_Q, M_LATCH_V0, M_LATCH_A,
    M_LATCH_B, M_STORE_CX, M_STORE_CY, M_STORE_CZ, M_LATCH_PT, M_STORE_T,
    M_DIV_START, M_SX_DIV, M_LOAD_OUT
  } misc_op_t;

  typedef struct packed {
    a_sel_t     a_sel;
    b_sel_t     b_sel;
    acc_op_t    acc_op;
    misc_op_t   misc;
    logic [2:0] cidx;
    logic [2:0] face;
    logic [1:0] corner;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic acc_neg;
    logic div_busy;
    logic out_free;
  } dp_status_t;

  function automatic logic [2:0] face_corner(input logic [2:0] f, input logic [1:0] k);
    logic [11:0] row;
    case (f)
      3'd0:    row = {3'd0, 3'd1, 3'd3, 3'd2};
      3'd1:    row = {3'd2, 3'd3, 3'd5, 3'd4};
      3'd2:    row = {3'd4, 3'd5, 3'd7, 3'd6};
      3'd3:    row = {3'd6, 3'd7, 3'd1, 3'd0};
      3'd4:    row = {3'd6, 3'd0, 3'd2, 3'd4};
      3'd5:    row = {3'd1, 3'd7, 3'd5, 3'd3};
      default: row = '0;
    endcase
    case (k)
      2'd0:    return row[11:9];
      2'd1:    return row[8:6];
      2'd2:    return row[5:3];
      default: return row[2:0];
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] box_x(input logic [2:0] i);
    return i[0] ? ONE_COORD : -ONE_COORD;
  endfunction

  function automatic logic signed [COORD_W-1:0] box_y(input logic [2:0] i);
    return (i[1] ^ i[2]) ? ONE_COORD : '0;
  endfunction

  function automatic logic signed [COORD_W-1:0] box_z(input logic [2:0] i);
    return i[2] ? ONE_COORD : -ONE_COORD;
  endfunction

endpackage

### sv/crcp_div.sv
// Sequential restoring divider for the projection quotient, with early saturation.
module crcp_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [crcp_pkg::NUM_W-1:0]  num,
  input  logic [crcp_pkg::DEN_W-1:0]         den,
  output logic                               busy,
  output logic signed [crcp_pkg::COORD_W-1:0] quo
);
  localparam int REM_W = 50;

  logic             busy_r;
  logic [3:0]       cnt_r;
  logic [REM_W-1:0] rem_r;
  logic [REM_W-1:0] dsr_r;
  logic [14:0]      q_r;
  logic             neg_r;
  logic signed [crcp_pkg::COORD_W-1:0] quo_r;

  logic [REM_W-1:0] mag;
  logic [REM_W-1:0] den_full;
  logic             fits;
  logic [REM_W-1:0] rem_sub;
  logic [14:0]      q_nxt;

  always_comb begin
    mag      = REM_W'(num[crcp_pkg::NUM_W-1] ? -num : num);
    den_full = REM_W'({den, 16'd0});
    fits     = rem_r >= dsr_r;
    rem_sub  = rem_r - dsr_r;
    q_nxt    = {q_r[13:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      neg_r <= num[crcp_pkg::NUM_W-1];
      q_r   <= '0;
      rem_r <= mag;
      dsr_r <= den_full << 14;
      cnt_r <= 4'd14;
      if (mag >= (den_full << 15)) begin
        // quotient magnitude of 2^15 or more: clamp at once
        quo_r  <= num[crcp_pkg::NUM_W-1] ? 16'sh8000 : 16'sh7fff;
        busy_r <= 1'b0;
      end else begin
        busy_r <= 1'b1;
      end
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_sub;
      end
      q_r   <= q_nxt;
      dsr_r <= dsr_r >> 1;
      cnt_r <= cnt_r - 4'd1;
      if (cnt_r == 4'd0) begin
        busy_r <= 1'b0;
        quo_r  <= neg_r ? -$signed({1'b0, q_nxt}) : $signed({1'b0, q_nxt});
      end
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

### sv/crcp_dp.sv
// Datapath: corner store, config registers, shared multiplier/accumulator, divider, output register.
module crcp_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [crcp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [crcp_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [1:0]                            in_mode,
  input  logic                                  in_reverse,
  input  crcp_pkg::dp_cmd_t                     cmd,
  output crcp_pkg::dp_status_t                  st,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic [2:0]                            out_face,
  output logic [1:0]                            out_corner,
  output logic signed [15:0]                    out_screen_x,
  output logic signed [15:0]                    out_screen_y,
  output logic                                  out_last
);
  localparam int CW = crcp_pkg::COORD_W;

  function automatic logic signed [CW-1:0] rnd_sat(input logic signed [crcp_pkg::ACC_W-1:0] v);
    logic signed [crcp_pkg::ACC_W-1:0] r;
    r = (v + 58'sd8192) >>> 14;
    if (r > 58'sd32767) return 16'sh7fff;
    if (r < -58'sd32768) return 16'sh8000;
    return r[CW-1:0];
  endfunction

  logic [crcp_pkg::FOCUS_W-1:0] focus_r;
  logic [crcp_pkg::TRIG_W-1:0]  cos_r, sin_r;
  logic [crcp_pkg::SCALE_W-1:0] vs_r;
  logic [crcp_pkg::CTR_W-1:0]   ctrx_r, ctry_r;
  logic [1:0]                   mode_r;
  logic                         rev_r;

  logic signed [CW-1:0] cor_x_r [8];
  logic signed [CW-1:0] cor_y_r [8];
  logic signed [CW-1:0] cor_z_r [8];

  logic signed [CW-1:0] rp_r, rq_r, x0_r, y0_r, z0_r, sx_r;
  logic signed [crcp_pkg::EX_W-1:0]   ex_r;
  logic signed [crcp_pkg::DIFF_W-1:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r;
  logic signed [crcp_pkg::OPA_W-1:0]  crx_r, cry_r, crz_r;
  logic signed [crcp_pkg::T_W-1:0]    t_r;
  logic [crcp_pkg::DEN_W-1:0]         d_r;
  logic signed [crcp_pkg::PROD_W-1:0] prod_r;
  crcp_pkg::acc_op_t                  op_q;
  logic signed [crcp_pkg::ACC_W-1:0]  acc_r;

  logic       out_valid_r, out_last_r;
  logic [2:0] out_face_r;
  logic [1:0] out_corner_r;
  logic signed [CW-1:0] out_sx_r, out_sy_r;

  logic signed [CW-1:0] rd_x, rd_y, rd_z, rot_p, rot_q, rnd_v;
  logic signed [crcp_pkg::OPA_W-1:0] opa;
  logic signed [crcp_pkg::OPB_W-1:0] opb, sin_s;
  logic signed [crcp_pkg::EX_W-1:0]  dx;
  logic       div_start, div_busy;
  logic signed [CW-1:0] div_quo;

  always_comb begin
    rd_x = cor_x_r[cmd.cidx];
    rd_y = cor_y_r[cmd.cidx];
    rd_z = cor_z_r[cmd.cidx];
    // P and Q are the two coordinates turned by the active axis
    case (mode_r)
      crcp_pkg::MODE_ROT_X: begin rot_p = rd_y; rot_q = rd_z; end
      crcp_pkg::MODE_ROT_Y: begin rot_p = rd_z; rot_q = rd_x; end
      default:              begin rot_p = rd_y; rot_q = rd_x; end
    endcase
    rnd_v = rnd_sat(acc_r);
    dx    = $signed({2'b00, focus_r}) - crcp_pkg::EX_W'(rd_x);
    sin_s = $signed({5'd0, sin_r});

    case (cmd.a_sel)
      crcp_pkg::A_RP: opa = crcp_pkg::OPA_W'(rp_r);
      crcp_pkg::A_RQ: opa = crcp_pkg::OPA_W'(rq_r);
      crcp_pkg::A_AX: opa = crcp_pkg::OPA_W'(ax_r);
      crcp_pkg::A_AY: opa = crcp_pkg::OPA_W'(ay_r);
      crcp_pkg::A_AZ: opa = crcp_pkg::OPA_W'(az_r);
      crcp_pkg::A_CX: opa = crx_r;
      crcp_pkg::A_CY: opa = cry_r;
      crcp_pkg::A_CZ: opa = crz_r;
      crcp_pkg::A_T:  opa = crcp_pkg::OPA_W'(t_r);
      crcp_pkg::A_D:  opa = $signed({17'd0, d_r});
      default:        opa = '0;
    endcase

    case (cmd.b_sel)
      crcp_pkg::B_C:    opb = $signed({5'd0, cos_r});
      crcp_pkg::B_S:    opb = rev_r ? -sin_s : sin_s;
      crcp_pkg::B_BX:   opb = crcp_pkg::OPB_W'(bx_r);
      crcp_pkg::B_BY:   opb = crcp_pkg::OPB_W'(by_r);
      crcp_pkg::B_BZ:   opb = crcp_pkg::OPB_W'(bz_r);
      crcp_pkg::B_EX:   opb = ex_r;
      crcp_pkg::B_Y0:   opb = crcp_pkg::OPB_W'(y0_r);
      crcp_pkg::B_Z0:   opb = crcp_pkg::OPB_W'(z0_r);
      crcp_pkg::B_VS:   opb = $signed({8'd0, vs_r});
      crcp_pkg::B_K:    opb = $signed({3'd0, crcp_pkg::STRETCH_Q16});
      crcp_pkg::B_CTRX: opb = $signed({8'd0, ctrx_r});
      crcp_pkg::B_CTRY: opb = $signed({8'd0, ctry_r});
      default:          opb = '0;
    endcase

    div_start = (cmd.misc == crcp_pkg::M_DIV_START) || (cmd.misc == crcp_pkg::M_SX_DIV);
  end

  // configuration and corner store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focus_r <= crcp_pkg::FOCUS_RST;
      cos_r   <= crcp_pkg::COS_RST;
      sin_r   <= crcp_pkg::SIN_RST;
      vs_r    <= crcp_pkg::SCALE_RST;
      ctrx_r  <= crcp_pkg::CTR_RST;
      ctry_r  <= crcp_pkg::CTR_RST;
      for (int i = 0; i < 8; i++) begin
        cor_x_r[i] <= crcp_pkg::box_x(3'(i));
        cor_y_r[i] <= crcp_pkg::box_y(3'(i));
        cor_z_r[i] <= crcp_pkg::box_z(3'(i));
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          crcp_pkg::REG_FOCUS: focus_r <= cfg_data[crcp_pkg::FOCUS_W-1:0];
          crcp_pkg::REG_COS:   cos_r   <= cfg_data[crcp_pkg::TRIG_W-1:0];
          crcp_pkg::REG_SIN:   sin_r   <= cfg_data[crcp_pkg::TRIG_W-1:0];
          crcp_pkg::REG_SCALE: vs_r    <= cfg_data[crcp_pkg::SCALE_W-1:0];
          crcp_pkg::REG_CTR_X: ctrx_r  <= cfg_data[crcp_pkg::CTR_W-1:0];
          crcp_pkg::REG_CTR_Y: ctry_r  <= cfg_data[crcp_pkg::CTR_W-1:0];
          default: ;
        endcase
      end
      if (cmd.misc == crcp_pkg::M_WRITE_P) begin
        case (mode_r)
          crcp_pkg::MODE_ROT_Y: cor_z_r[cmd.cidx] <= rnd_v;
          default:              cor_y_r[cmd.cidx] <= rnd_v;
        endcase
      end
      if (cmd.misc == crcp_pkg::M_WRITE_Q) begin
        case (mode_r)
          crcp_pkg::MODE_ROT_X: cor_z_r[cmd.cidx] <= rnd_v;
          default:              cor_x_r[cmd.cidx] <= rnd_v;
        endcase
      end
    end
  end

  // multiplier, accumulator and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_q <= crcp_pkg::ACC_NONE;
    end else begin
      op_q <= cmd.acc_op;
    end
    prod_r <= opa * opb;
    case (op_q)
      crcp_pkg::ACC_LD:    acc_r <= crcp_pkg::ACC_W'(prod_r);
      crcp_pkg::ACC_ADD:   acc_r <= acc_r + crcp_pkg::ACC_W'(prod_r);
      crcp_pkg::ACC_SUB:   acc_r <= acc_r - crcp_pkg::ACC_W'(prod_r);
      crcp_pkg::ACC_ADD16: acc_r <= acc_r + (crcp_pkg::ACC_W'(prod_r) <<< 16);
      default: ;
    endcase
    case (cmd.misc)
      crcp_pkg::M_TAKE_IN: begin
        mode_r <= in_mode;
        rev_r  <= in_reverse;
      end
      crcp_pkg::M_LATCH_ROT: begin
        rp_r <= rot_p;
        rq_r <= rot_q;
      end
      crcp_pkg::M_LATCH_V0: begin
        x0_r <= rd_x;
        y0_r <= rd_y;
        z0_r <= rd_z;
        ex_r <= dx;
      end
      crcp_pkg::M_LATCH_A: begin
        ax_r <= crcp_pkg::DIFF_W'(rd_x) - crcp_pkg::DIFF_W'(x0_r);
        ay_r <= crcp_pkg::DIFF_W'(rd_y) - crcp_pkg::DIFF_W'(y0_r);
        az_r <= crcp_pkg::DIFF_W'(rd_z) - crcp_pkg::DIFF_W'(z0_r);
      end
      crcp_pkg::M_LATCH_B: begin
        bx_r <= crcp_pkg::DIFF_W'(rd_x) - crcp_pkg::DIFF_W'(x0_r);
        by_r <= crcp_pkg::DIFF_W'(rd_y) - crcp_pkg::DIFF_W'(y0_r);
        bz_r <= crcp_pkg::DIFF_W'(rd_z) - crcp_pkg::DIFF_W'(z0_r);
      end
      crcp_pkg::M_STORE_CX: crx_r <= acc_r[crcp_pkg::OPA_W-1:0];
      crcp_pkg::M_STORE_CY: cry_r <= acc_r[crcp_pkg::OPA_W-1:0];
      crcp_pkg::M_STORE_CZ: crz_r <= acc_r[crcp_pkg::OPA_W-1:0];
      crcp_pkg::M_LATCH_PT: begin
        rp_r <= rd_y;
        rq_r <= rd_z;
        // a point at or behind the eye divides by one LSB
        d_r  <= (dx < 20'sd1) ? 19'd1 : dx[crcp_pkg::DEN_W-1:0];
      end
      crcp_pkg::M_STORE_T: t_r  <= acc_r[crcp_pkg::T_W-1:0];
      crcp_pkg::M_SX_DIV:  sx_r <= div_quo;
      default: ;
    endcase
  end

  crcp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc_r[crcp_pkg::NUM_W-1:0]),
    .den   (d_r),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.misc == crcp_pkg::M_LOAD_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.misc == crcp_pkg::M_LOAD_OUT) begin
      out_face_r   <= cmd.face;
      out_corner_r <= cmd.corner;
      out_last_r   <= cmd.last;
      out_sx_r     <= sx_r;
      out_sy_r     <= div_quo;
    end
  end

  assign st.acc_neg  = acc_r[crcp_pkg::ACC_W-1];
  assign st.div_busy = div_busy;
  assign st.out_free = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_face     = out_face_r;
  assign out_corner   = out_corner_r;
  assign out_screen_x = out_sx_r;
  assign out_screen_y = out_sy_r;
  assign out_last     = out_last_r;

endmodule

### sv/crcp_ctrl.sv
// Controller: sequences rotation, face culling and per-point projection through the datapath.
module crcp_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_mode,
  output logic                  in_ready,
  input  crcp_pkg::dp_status_t  st,
  output crcp_pkg::dp_cmd_t     cmd
);
  typedef enum logic [2:0] {S_IDLE, S_ROT, S_CULL, S_SEEK, S_PROJ} state_t;

  state_t     state_r, state_nxt;
  logic [3:0] step_r, step_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [1:0] k_r, k_nxt;
  logic [5:0] vis_r, vis_nxt;
  logic       more_faces;

  always_comb begin
    more_faces = 1'b0;
    for (int j = 0; j < crcp_pkg::NUM_FACES; j++) begin
      if (3'(j) > idx_r && vis_r[j]) more_faces = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    k_nxt     = k_r;
    vis_nxt   = vis_r;
    in_ready  = 1'b0;
    cmd.a_sel  = crcp_pkg::A_RP;
    cmd.b_sel  = crcp_pkg::B_C;
    cmd.acc_op = crcp_pkg::ACC_NONE;
    cmd.misc   = crcp_pkg::M_NONE;
    cmd.cidx   = idx_r;
    cmd.face   = idx_r;
    cmd.corner = k_r;
    cmd.last   = (k_r == 2'd3) && !more_faces;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.misc  = crcp_pkg::M_TAKE_IN;
          step_nxt  = '0;
          idx_nxt   = '0;
          vis_nxt   = '0;
          state_nxt = (in_mode == crcp_pkg::MODE_HOLD) ? S_CULL : S_ROT;
        end
      end

      S_ROT: begin
        step_nxt = step_r + 4'd1;
        case (step_r)
          4'd0: cmd.misc = crcp_pkg::M_LATCH_ROT;
          4'd1: begin
            cmd.a_sel = crcp_pkg::A_RP; cmd.b_sel = crcp_pkg::B_C;
            cmd.acc_op = crcp_pkg::ACC_LD;
          end
          4'd2: begin
            cmd.a_sel = crcp_pkg::A_RQ; cmd.b_sel = crcp_pkg::B_S;
            cmd.acc_op = crcp_pkg::ACC_SUB;
          end
          4'd3: begin
            cmd.a_sel = crcp_pkg::A_RQ; cmd.b_sel = crcp_pkg::B_C;
            cmd.acc_op = crcp_pkg::ACC_LD;
          end
          4'd4: begin
            cmd.a_sel = crcp_pkg::A_RP; cmd.b_sel = crcp_pkg::B_S;
            cmd.acc_op = crcp_pkg::ACC_ADD; cmd.misc = crcp_pkg::M_WRITE_P;
          end
          4'd6: begin
            cmd.misc = crcp_pkg::M_WRITE_Q;
            step_nxt = '0;
            idx_nxt  = idx_r + 3'd1;
            if (idx_r == 3'd7) state_nxt = S_CULL;
          end
          default: ;
        endcase
      end

      S_CULL: begin
        step_nxt = step_r + 4'd1;
        case (step_r)
          4'd0: begin
            cmd.misc = crcp_pkg::M_LATCH_V0; cmd.cidx = crcp_pkg::face_corner(idx_r, 2'd0);
          end
          4'd1: begin
            cmd.misc = crcp_pkg::M_LATCH_A; cmd.cidx = crcp_pkg::face_corner(idx_r, 2'd1);
          end
          4'd2: begin
            cmd.misc = crcp_pkg::M_LATCH_B; cmd.cidx = crcp_pkg::face_corner(idx_r, 2'd3);
          end
          4'd3: begin
            cmd.a_sel = crcp_pkg::A_AY; cmd.b_sel = crcp_pkg::B_BZ;
            cmd.acc_op = crcp_pkg::ACC_LD;
          end
          4'd4: begin
            cmd.a_sel = crcp_pkg::A_AZ; cmd.b_sel = crcp_pkg::B_BY;
            cmd.acc_op = crcp_pkg::ACC_SUB;
          end
          4'd5: begin
            cmd.a_sel = crcp_pkg::A_AZ; cmd.b_sel = crcp_pkg::B_BX;
            cmd.acc_op = crcp_pkg::ACC_LD;
          end
          4'd6: begin
            cmd.a_sel = crcp_pkg::A_AX; cmd.b_sel = crcp_pkg::B_BZ;
            cmd.acc_op = crcp_pkg::ACC_SUB; cmd.misc = crcp_pkg::M_STORE_CX;
          end
          4'd7: begin
            cmd.a_sel = crcp_pkg::A_AX; cmd.b_sel = crcp_pkg::B_BY;
            cmd.acc_op = crcp_pkg::ACC_LD;
          end
          4'd8: begin
            cmd.a_sel = crcp_pkg::A_AY; cmd.b_sel = crcp_pkg::B_BX;
            cmd.acc_op = crcp_pkg::ACC_SUB; cmd.misc = crcp_pkg::M_STORE_CY;
          end
          4'd9: begin
            cmd.a_sel = crcp_pkg::A_CX; cmd.b_sel = crcp_pkg::B_EX;
            cmd.acc_op = crcp_pkg::ACC_LD;
          end
          4'd10: begin
            cmd.a_sel = crcp_pkg::A_CY; cmd.b_sel = crcp_pkg::B_Y0;
            cmd.acc_op = crcp_pkg::ACC_SUB; cmd.misc = crcp_pkg::M_STORE_CZ;
          end
          4'd11: begin
            cmd.a_sel = crcp_pkg::A_CZ; cmd.b_sel = crcp_pkg::B_Z0;
            cmd.acc_op = crcp_pkg::ACC_SUB;
          end
          4'd13: begin
            // visible when the triple product is negative
            vis_nxt[idx_r] = st.acc_neg;
            step_nxt = '0;
            if (idx_r == 3'(crcp_pkg::NUM_FACES - 1)) begin
              idx_nxt   = '0;
              state_nxt = S_SEEK;
            end else begin
              idx_nxt = idx_r + 3'd1;
            end
          end
          default: ;
        endcase
      end

      S_SEEK: begin
        if (idx_r == 3'(crcp_pkg::NUM_FACES)) begin
          state_nxt = S_IDLE;
        end else if (vis_r[idx_r]) begin
          step_nxt  = '0;
          k_nxt     = '0;
          state_nxt = S_PROJ;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end

      S_PROJ: begin
        cmd.cidx = crcp_pkg::face_corner(idx_r, k_r);
        step_nxt = step_r + 4'd1;
        case (step_r)
          4'd0: cmd.misc = crcp_pkg::M_LATCH_PT;
          4'd1: begin
            cmd.a_sel = crcp_pkg::A_RP; cmd.b_sel = crcp_pkg::B_VS;
            cmd.acc_op = crcp_pkg::ACC_LD;
          end
          4'd3: cmd.misc = crcp_pkg::M_STORE_T;
          4'd4: begin
            cmd.a_sel = crcp_pkg::A_T; cmd.b_sel = crcp_pkg::B_K;
            cmd.acc_op = crcp_pkg::ACC_LD;
          end
          4'd5: begin
            cmd.a_sel = crcp_pkg::A_D; cmd.b_sel = crcp_pkg::B_CTRX;
            cmd.acc_op = crcp_pkg::ACC_ADD16;
          end
          4'd7: begin
            cmd.misc = crcp_pkg::M_DIV_START;
            cmd.a_sel = crcp_pkg::A_RQ; cmd.b_sel = crcp_pkg::B_VS;
            cmd.acc_op = crcp_pkg::ACC_LD;
          end
          4'd9: cmd.misc = crcp_pkg::M_STORE_T;
          4'd10: begin
            cmd.a_sel = crcp_pkg::A_T; cmd.b_sel = crcp_pkg::B_K;
            cmd.acc_op = crcp_pkg::ACC_LD;
          end
          4'd11: begin
            cmd.a_sel = crcp_pkg::A_D; cmd.b_sel = crcp_pkg::B_CTRY;
            cmd.acc_op = crcp_pkg::ACC_ADD16;
          end
          4'd13: begin
            // hold until x quotient is done, then start the y division
            if (st.div_busy) begin
              step_nxt = step_r;
            end else begin
              cmd.misc = crcp_pkg::M_SX_DIV;
            end
          end
          4'd14: begin
            if (st.div_busy || !st.out_free) begin
              step_nxt = step_r;
            end else begin
              cmd.misc = crcp_pkg::M_LOAD_OUT;
              step_nxt = '0;
              if (k_r == 2'd3) begin
                idx_nxt   = idx_r + 3'd1;
                state_nxt = S_SEEK;
              end else begin
                k_nxt = k_r + 2'd1;
              end
            end
          end
          default: ;
        endcase
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      idx_r   <= '0;
      k_r     <= '0;
      vis_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      idx_r   <= idx_nxt;
      k_r     <= k_nxt;
      vis_r   <= vis_nxt;
    end
  end

endmodule

### sv/cube_rotate_cull_project.sv
// Top level of the cube rotate, cull and perspective projection block.
// Usage:
//  - Input channel (in_valid/in_ready, in_mode, in_reverse): one transaction is one
//    command. in_mode rotates the eight stored box corners about X, Y or Z by the
//    configured step angle (in_reverse negates the sine), or leaves them in place.
//  - Result channel (out_valid/out_ready): for each visible face in face order, four
//    projected screen points; out_last marks the final point of the command. A
//    command with no visible face yields no transaction.
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready; write
//    only while the block is idle. Indexes above five are ignored.
// Sequence: the command is taken, then the corners are rotated (skipped for the hold mode),
// the faces are culled, the face search runs and each point of a visible face is projected
// with two 15-step serial divisions sharing one divider. Commands are taken one at a time;
// the next one is accepted once the face search after the last point has run out.
// Reset (synchronous, rst_n low) restores the unit box corners and the default
// configuration. When the receiver stalls, the finished point holds in the output
// register and the sequencer stops at the next point until that register frees.
module cube_rotate_cull_project (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [crcp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [crcp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_mode,
  input  logic                                in_reverse,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0]                          out_face,
  output logic [1:0]                          out_corner,
  output logic signed [15:0]                  out_screen_x,
  output logic signed [15:0]                  out_screen_y,
  output logic                                out_last
);

  crcp_pkg::dp_cmd_t    cmd;
  crcp_pkg::dp_status_t st;

  // config registers never back-pressure
  assign cfg_ready = 1'b1;

  crcp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  crcp_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_mode      (in_mode),
    .in_reverse   (in_reverse),
    .cmd          (cmd),
    .st           (st),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_face     (out_face),
    .out_corner   (out_corner),
    .out_screen_x (out_screen_x),
    .out_screen_y (out_screen_y),
    .out_last     (out_last)
  );

  // a taken command keeps the block busy for at least the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice in a row");

  // no division may still run while idle
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !st.div_busy)
    else $error("divider busy while idle");

  // emitted face index stays within the six faces
  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_face < 3'd6))
    else $error("face index out of range");

  // a point is only loaded into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.misc == crcp_pkg::M_LOAD_OUT) |-> st.out_free)
    else $error("output register overwritten");

endmodule
